/* src/tli_pkg.sv */
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants
// Operation codes and the beat carried from the front end to the back end.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int IDX_W = 8;
    localparam int DAT_W = 32;

    // One classified item in the queue between front and back end
    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  index;
        logic [DAT_W-1:0]  arg;
        logic [DAT_W-1:0]  value;
    } item_t;

endpackage

/* src/tli_front.sv */
// ----------------------------------------------------------------------------
// tli_front: input unpacking and item queue
// Accepts stream beats, decodes the fields and holds them in a short queue.
// ----------------------------------------------------------------------------
module tli_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [111:0]         in_data,
    output logic                 q_valid,
    input  logic                 q_ready,
    output tli_pkg::item_t       q_item
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    tli_pkg::item_t        mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]         wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]           cnt_reg, cnt_next;
    tli_pkg::item_t        din;
    logic                  push, pop;

    // Classify: queries carry query_arg in the arg slot
    always_comb
    begin
        din.op    = in_data[0];
        din.index = in_data[8:1];
        din.value = in_data[72:41];
        if (in_data[0] == tli_pkg::OP_QUERY)
            din.arg = in_data[104:73];
        else
            din.arg = in_data[40:9];
    end

    assign in_ready = (cnt_reg != (PW+1)'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rd_reg];

    // Advance pointers
    always_comb
    begin
        wr_next  = push ? ((wr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = pop  ? ((rd_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store beat
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= din;
    end

endmodule

/* src/tli_back.sv */
// ----------------------------------------------------------------------------
// tli_back: table, bisection, divider and interpolation
// Writes loads to the table and runs one query at a time through a sequencer.
// ----------------------------------------------------------------------------
module tli_back #(
    parameter int TABLE_DEPTH = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [8:0]           entry_count,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  tli_pkg::item_t       q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [40:0]          out_data
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = AW + 1;
    localparam int NW  = 33 + FRAC_BITS;
    localparam int DCW = $clog2(NW + 1);
    localparam int FW  = FRAC_BITS + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_RDN   = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_BIS   = 4'd4;
    localparam logic [3:0] S_BISW  = 4'd5;
    localparam logic [3:0] S_LO    = 4'd6;
    localparam logic [3:0] S_HI    = 4'd7;
    localparam logic [3:0] S_PREP  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_MUL1  = 4'd10;
    localparam logic [3:0] S_MUL2  = 4'd11;
    localparam logic [3:0] S_SUM   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [31:0]    args_mem [TABLE_DEPTH];
    logic [31:0]    vals_mem [TABLE_DEPTH];
    logic [31:0]    rd_arg_reg, rd_val_reg;
    logic [AW-1:0]  raddr;

    logic [3:0]     state_reg, state_next;
    logic [CW-1:0]  lo_reg, hi_reg, mid, n_live;
    logic signed [31:0] q_reg, a1_reg, a2_reg, y1_reg, y2_reg, first_reg;
    logic [NW-1:0]  num_reg, rem_reg;
    logic [33:0]    den_reg;
    logic [FW-1:0]  frac_reg;
    logic [DCW-1:0] dcnt_reg;
    logic signed [FW+32:0] p1_reg, p2_reg;
    logic           ovld_reg;
    logic [40:0]    odata_reg;
    logic [NW:0]    rtrial;
    logic signed [33:0] num_s, den_s;
    logic signed [FW+33:0] sum_w;
    logic signed [FW+33:0] rnd;
    logic           oor_hit;

    // Clamp the live entry count
    always_comb
    begin
        if (entry_count < 9'd2)
            n_live = CW'(2);
        else if (32'(entry_count) > 32'(TABLE_DEPTH))
            n_live = CW'(TABLE_DEPTH);
        else
            n_live = CW'(entry_count);
    end

    assign mid = CW'((lo_reg + hi_reg) >> 1);

    // Table read address per state
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  raddr = '0;
            S_RD0:   raddr = AW'(n_live - 1'b1);
            S_RDN:   raddr = AW'(n_live - 1'b1);
            S_BIS:   raddr = mid[AW-1:0];
            S_HI:    raddr = lo_reg[AW-1:0] + 1'b1;
            default: raddr = lo_reg[AW-1:0];
        endcase
    end

    // Table write on load, registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid && q_item.op == tli_pkg::OP_LOAD
            && 32'(q_item.index) < 32'(TABLE_DEPTH))
        begin
            args_mem[AW'(q_item.index)] <= q_item.arg;
            vals_mem[AW'(q_item.index)] <= q_item.value;
        end
        rd_arg_reg <= args_mem[raddr];
        rd_val_reg <= vals_mem[raddr];
    end

    assign q_ready = (state_reg == S_IDLE) && (q_item.op == tli_pkg::OP_LOAD || !ovld_reg);
    assign num_s   = 34'(q_reg) - 34'(a1_reg);
    assign den_s   = 34'(a2_reg) - 34'(a1_reg);
    assign rtrial  = {rem_reg, num_reg[NW-1]};
    assign sum_w   = (FW+34)'(p1_reg) + (FW+34)'(p2_reg);
    assign rnd     = (sum_w + ((FW+34)'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
    assign oor_hit = (q_reg < first_reg) || (q_reg > $signed(rd_arg_reg));

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_valid && q_ready && q_item.op == tli_pkg::OP_QUERY) state_next = S_RD0;
            S_RD0:   state_next = S_RDN;
            S_RDN:   state_next = S_CHK;
            S_CHK:   state_next = oor_hit ? S_IDLE : S_BIS;
            S_BIS:   state_next = (hi_reg - lo_reg > CW'(1)) ? S_BISW : S_LO;
            S_BISW:  state_next = S_BIS;
            S_LO:    state_next = S_HI;
            S_HI:    state_next = S_PREP;
            S_PREP:  state_next = S_DIV;
            S_DIV:   if (dcnt_reg == '0) state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_SUM;
            S_SUM:   state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid && out_ready)
                ovld_reg <= 1'b0;
            if (state_reg == S_CHK && oor_hit)
                ovld_reg <= 1'b1;
            if (state_reg == S_OUT)
                ovld_reg <= 1'b1;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                q_reg  <= $signed(q_item.arg);
                lo_reg <= '0;
            end
            S_RD0:
            begin
                hi_reg    <= n_live - 1'b1;
                first_reg <= $signed(rd_arg_reg);
            end
            S_CHK:
                odata_reg <= {1'b1, 8'd0, 32'd0};
            S_BISW:
            begin
                if (q_reg <= $signed(rd_arg_reg))
                    hi_reg <= mid;
                else
                    lo_reg <= mid;
            end
            S_HI:
            begin
                a1_reg <= $signed(rd_arg_reg);
                y1_reg <= $signed(rd_val_reg);
            end
            S_PREP:
            begin
                a2_reg   <= $signed(rd_arg_reg);
                y2_reg   <= $signed(rd_val_reg);
                dcnt_reg <= DCW'(NW);
                rem_reg  <= '0;
            end
            S_DIV:
            begin
                if (dcnt_reg == DCW'(NW))
                begin
                    den_reg <= 34'(den_s);
                    num_reg <= NW'(num_s) << FRAC_BITS;
                    if (den_s <= 0 || num_s <= 0)
                        frac_reg <= '0;
                    else if (num_s >= den_s)
                        frac_reg <= FW'(1) << FRAC_BITS;
                    else
                        frac_reg <= '1;
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
                else
                begin
                    if (rtrial >= (NW+1)'(den_reg))
                        rem_reg <= NW'(rtrial - (NW+1)'(den_reg));
                    else
                        rem_reg <= NW'(rtrial);
                    num_reg  <= {num_reg[NW-2:0], rtrial >= (NW+1)'(den_reg)};
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
            end
            S_MUL1:
            begin
                if (frac_reg == '1)
                    frac_reg <= FW'(num_reg);
            end
            S_MUL2:
            begin
                p1_reg <= (FW+33)'(y1_reg * $signed({1'b0, (FW'(1) << FRAC_BITS) - frac_reg}));
                p2_reg <= (FW+33)'(y2_reg * $signed({1'b0, frac_reg}));
            end
            S_SUM:
                odata_reg <= {1'b0, lo_reg[7:0], rnd[31:0]};
            default: ;
        endcase
    end

    assign out_valid = ovld_reg && (state_reg == S_IDLE);
    assign out_data  = odata_reg;

endmodule

/* src/table_linear_interpolation_unit.sv */
// A load is written to the table from the queue while the back end is idle; a
// query runs through table reads, bisection, the divider and interpolation for
// n live entries (bisection reads, one quotient bit per divider cycle), and an
// argument out of range ends its query after the range check.
// Throughput: one query at a time; loads one per cycle while the back end is idle; reset is asynchronous
// active low, clears control, sets entry_count to 2 and leaves the table as is.
// ----------------------------------------------------------------------------
// table_linear_interpolation_unit: piecewise linear table lookup
// Front end queues beats, back end searches the table and interpolates.
// ----------------------------------------------------------------------------
module table_linear_interpolation_unit #(
    parameter int TABLE_DEPTH = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [111:0]  s_axis_tdata,   // operation, entry_index, entry_arg,
                                          // entry_value, query_arg
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [47:0]   m_axis_tdata,   // interp_value, interval_index, out_of_range
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [8:0]    cfg_data
);

    logic [8:0]           count_reg;
    logic                 qv, qr;
    tli_pkg::item_t       qi;
    logic [40:0]          od;

    assign cfg_ready = 1'b1;

    // Hold entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 9'd2;
        else if (cfg_valid && cfg_ready)
            count_reg <= cfg_data;
    end

    tli_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .q_valid(qv), .q_ready(qr), .q_item(qi)
    );

    tli_back #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .entry_count(count_reg),
        .q_valid(qv), .q_ready(qr), .q_item(qi),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(od)
    );

    assign m_axis_tdata = {7'd0, od};

    // Out of range results carry zero value and index
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[40] |-> m_axis_tdata[39:0] == 40'd0)
        else $error("out of range result not zero");

    // Interval index stays below the top entry
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:32] != 8'hFF)
        else $error("interval index out of bounds");

endmodule
